// ===== design/cil_pkg.sv =====
// Shared types and character codes for the CIGAR interval liftover block.
package cil_pkg;

  localparam int unsigned POS_W  = 32;
  localparam int unsigned LIFT_W = POS_W + 1;

  localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE = 8'h39;  // '9'
  localparam logic [7:0] CHAR_DEL  = 8'h44;  // 'D'
  localparam logic [7:0] CHAR_INS  = 8'h49;  // 'I'

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_CIGAR  = 1'b1
  } item_op_e;

  typedef enum logic [1:0] {
    LANE_SEARCHING = 2'd0,
    LANE_FOUND     = 2'd1,
    LANE_FAILED    = 2'd2
  } lane_status_e;

  // Control from the walk logic to each lane
  typedef struct packed {
    logic load;    // header transfer: set up the lane
    logic apply;   // query-advancing op with nonzero run
    logic is_ins;  // that op is an insertion
  } lane_ctrl_t;

endpackage

// ===== design/cil_lane.sv =====
// One liftover lane: oriented query position, search status and lifted target position.
module cil_lane (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cil_pkg::lane_ctrl_t             ctrl_i,
  input  logic                            minus_i,
  input  logic [cil_pkg::POS_W-1:0]       pos_i,
  input  logic [cil_pkg::POS_W-1:0]       qlen_i,
  input  logic [cil_pkg::POS_W-1:0]       ystart_i,
  input  logic [cil_pkg::POS_W-1:0]       yend_i,
  input  logic [cil_pkg::POS_W-1:0]       qcur_i,
  input  logic [cil_pkg::POS_W-1:0]       tcur_i,
  input  logic [cil_pkg::POS_W-1:0]       len_i,
  output cil_pkg::lane_status_e           status_o,
  output logic [cil_pkg::LIFT_W-1:0]      lift_o
);

  logic [cil_pkg::POS_W-1:0]  opos_q, opos_d;
  cil_pkg::lane_status_e      status_q, status_d;
  logic [cil_pkg::LIFT_W-1:0] lift_q, lift_d;

  logic [cil_pkg::POS_W-1:0]  hdr_pos;
  logic [cil_pkg::POS_W-1:0]  offset;
  logic                       hdr_fail;
  logic                       hit;

  always_comb begin
    hdr_fail = 1'b0;
    hdr_pos  = pos_i;
    if (minus_i) begin
      if (pos_i >= qlen_i) begin
        hdr_fail = 1'b1;
      end else begin
        hdr_pos = qlen_i - pos_i - cil_pkg::POS_W'(1);
      end
    end
    if (hdr_pos < ystart_i || hdr_pos >= yend_i) begin
      hdr_fail = 1'b1;
    end
  end

  assign offset = opos_q - qcur_i;
  assign hit    = (status_q == cil_pkg::LANE_SEARCHING) && (opos_q >= qcur_i) &&
                  (offset < len_i);

  always_comb begin
    opos_d   = opos_q;
    status_d = status_q;
    lift_d   = lift_q;
    if (ctrl_i.load) begin
      opos_d   = hdr_pos;
      status_d = hdr_fail ? cil_pkg::LANE_FAILED : cil_pkg::LANE_SEARCHING;
      lift_d   = '0;
    end else if (ctrl_i.apply && hit) begin
      status_d = cil_pkg::LANE_FOUND;
      // inside an insertion the lane sits on the target cursor
      lift_d   = ctrl_i.is_ins ? {1'b0, tcur_i}
                               : {1'b0, tcur_i} + {1'b0, offset};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opos_q   <= '0;
      status_q <= cil_pkg::LANE_SEARCHING;
      lift_q   <= '0;
    end else begin
      opos_q   <= opos_d;
      status_q <= status_d;
      lift_q   <= lift_d;
    end
  end

  assign status_o = status_q;
  assign lift_o   = lift_q;

endmodule

// ===== design/cigar_interval_liftover.sv =====
// A transfer passes through the input register, the walk/lane state and the result register, in that order.
// Throughput: one item per cycle; the input register, the walk/lane state and the
// result register move together whenever the result register is empty or taken.
// Reset clears the walk state, both lanes (searching) and all valid flags; no
// result is pending after reset until a header and a last CIGAR character arrive.
module cigar_interval_liftover (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  cigar_char_i,
  input  logic        last_char_i,
  input  logic        strand_minus_i,
  input  logic [31:0] query_len_i,
  input  logic [31:0] query_start_i,
  input  logic [31:0] query_end_i,
  input  logic [31:0] target_start_i,
  input  logic [31:0] target_end_i,
  input  logic [31:0] target_len_i,
  input  logic [31:0] region_begin_i,
  input  logic [31:0] region_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] lifted_begin_o,
  output logic [31:0] lifted_end_o,
  output logic        trim_five_o,
  output logic        trim_three_o
);

  localparam int unsigned PW = cil_pkg::POS_W;
  localparam int unsigned LW = cil_pkg::LIFT_W;

  // input register
  logic          s0_valid_q, s0_valid_d;
  logic          op_q;
  logic [7:0]    char_q;
  logic          last_q;
  logic          minus_in_q;
  logic [PW-1:0] qlen_q, qst_q, qen_q, tst_in_q, ten_in_q, tlen_in_q, rb_q, re_q;

  // walk state
  logic          minus_q, minus_d;
  logic [PW-1:0] tgt_start_q, tgt_start_d;
  logic [PW-1:0] tgt_end_q, tgt_end_d;
  logic [PW-1:0] tgt_len_q, tgt_len_d;
  logic          interval_ok_q, interval_ok_d;
  logic [PW-1:0] run_len_q, run_len_d;
  logic          run_any_q, run_any_d;
  logic [PW-1:0] qcur_q, qcur_d;
  logic [PW-1:0] tcur_q, tcur_d;
  logic          fin_q, fin_d;

  // result register
  logic          out_valid_q, out_valid_d;
  logic [PW-1:0] lb_q, le_q;
  logic          t5_q, t3_q;

  logic          advance, accept, proc;
  logic          is_hdr, is_digit, do_op, is_del, is_ins;
  logic [3:0]    digit;
  logic [PW-1:0] ystart, yend, far_pos;
  logic [PW-1:0] pos0, pos1;
  cil_pkg::lane_ctrl_t   lane_ctrl;
  cil_pkg::lane_status_e status0, status1;
  logic [LW-1:0] lift0, lift1;

  logic          t5, t3;
  logic [LW-1:0] tb, te, tlen;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s0_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign proc       = s0_valid_q && advance;

  assign s0_valid_d = accept ? 1'b1 : (advance ? 1'b0 : s0_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= s0_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= operation_i;
      char_q     <= cigar_char_i;
      last_q     <= last_char_i;
      minus_in_q <= strand_minus_i;
      qlen_q     <= query_len_i;
      qst_q      <= query_start_i;
      qen_q      <= query_end_i;
      tst_in_q   <= target_start_i;
      ten_in_q   <= target_end_i;
      tlen_in_q  <= target_len_i;
      rb_q       <= region_begin_i;
      re_q       <= region_end_i;
    end
  end

  // decode of the item in the input register
  assign is_hdr   = (op_q == cil_pkg::OP_HEADER);
  assign is_digit = (char_q >= cil_pkg::CHAR_ZERO) && (char_q <= cil_pkg::CHAR_NINE);
  assign digit    = 4'(char_q - cil_pkg::CHAR_ZERO);
  assign do_op    = !is_hdr && !is_digit && run_any_q;
  assign is_del   = (char_q == cil_pkg::CHAR_DEL);
  assign is_ins   = (char_q == cil_pkg::CHAR_INS);

  assign ystart  = minus_in_q ? (qlen_q - qen_q) : qst_q;
  assign yend    = minus_in_q ? (qlen_q - qst_q) : qen_q;
  assign far_pos = re_q - PW'(1);
  assign pos0    = minus_in_q ? far_pos : rb_q;
  assign pos1    = minus_in_q ? rb_q : far_pos;

  assign lane_ctrl.load   = proc && is_hdr;
  assign lane_ctrl.apply  = proc && do_op && !is_del;
  assign lane_ctrl.is_ins = is_ins;

  always_comb begin
    minus_d       = minus_q;
    tgt_start_d   = tgt_start_q;
    tgt_end_d     = tgt_end_q;
    tgt_len_d     = tgt_len_q;
    interval_ok_d = interval_ok_q;
    run_len_d     = run_len_q;
    run_any_d     = run_any_q;
    qcur_d        = qcur_q;
    tcur_d        = tcur_q;
    fin_d         = fin_q;
    if (advance) begin
      fin_d = 1'b0;
    end
    if (proc) begin
      if (is_hdr) begin
        minus_d       = minus_in_q;
        tgt_start_d   = tst_in_q;
        tgt_end_d     = ten_in_q;
        tgt_len_d     = tlen_in_q;
        interval_ok_d = (rb_q < re_q);
        run_len_d     = '0;
        run_any_d     = 1'b0;
        qcur_d        = ystart;
        tcur_d        = tst_in_q;
      end else begin
        if (is_digit) begin
          // times ten as two shifts and an add
          run_len_d = (run_len_q << 3) + (run_len_q << 1) + PW'(digit);
          if (digit != 4'd0) begin
            run_any_d = 1'b1;
          end
        end else if (run_any_q) begin
          if (is_del) begin
            tcur_d = tcur_q + run_len_q;
          end else begin
            qcur_d = qcur_q + run_len_q;
            if (!is_ins) begin
              tcur_d = tcur_q + run_len_q;
            end
          end
          run_len_d = '0;
          run_any_d = 1'b0;
        end
        if (last_q && interval_ok_q) begin
          interval_ok_d = 1'b0;
          fin_d         = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minus_q       <= 1'b0;
      tgt_start_q   <= '0;
      tgt_end_q     <= '0;
      tgt_len_q     <= '0;
      interval_ok_q <= 1'b0;
      run_len_q     <= '0;
      run_any_q     <= 1'b0;
      qcur_q        <= '0;
      tcur_q        <= '0;
      fin_q         <= 1'b0;
    end else begin
      minus_q       <= minus_d;
      tgt_start_q   <= tgt_start_d;
      tgt_end_q     <= tgt_end_d;
      tgt_len_q     <= tgt_len_d;
      interval_ok_q <= interval_ok_d;
      run_len_q     <= run_len_d;
      run_any_q     <= run_any_d;
      qcur_q        <= qcur_d;
      tcur_q        <= tcur_d;
      fin_q         <= fin_d;
    end
  end

  cil_lane u_lane0 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .minus_i  (minus_in_q),
    .pos_i    (pos0),
    .qlen_i   (qlen_q),
    .ystart_i (ystart),
    .yend_i   (yend),
    .qcur_i   (qcur_q),
    .tcur_i   (tcur_q),
    .len_i    (run_len_q),
    .status_o (status0),
    .lift_o   (lift0)
  );

  cil_lane u_lane1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .minus_i  (minus_in_q),
    .pos_i    (pos1),
    .qlen_i   (qlen_q),
    .ystart_i (ystart),
    .yend_i   (yend),
    .qcur_i   (qcur_q),
    .tcur_i   (tcur_q),
    .len_i    (run_len_q),
    .status_o (status1),
    .lift_o   (lift1)
  );

  // result from the state left by the last character
  assign t5   = (status0 != cil_pkg::LANE_FOUND);
  assign t3   = (status1 != cil_pkg::LANE_FOUND);
  assign tb   = t5 ? {1'b0, tgt_start_q} : lift0;
  assign te   = t3 ? {1'b0, tgt_end_q} : lift1 + LW'(1);
  assign tlen = {1'b0, tgt_len_q};

  assign out_valid_d = advance ? (fin_q && (te > tb)) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && fin_q) begin
      lb_q <= (tb > tlen) ? tgt_len_q : tb[PW-1:0];
      le_q <= (te > tlen) ? tgt_len_q : te[PW-1:0];
      t5_q <= t5;
      t3_q <= t3;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign lifted_begin_o = lb_q;
  assign lifted_end_o   = le_q;
  assign trim_five_o    = t5_q;
  assign trim_three_o   = t3_q;

endmodule
